>>> rtl/ptt_pkg.sv
// Shared widths, constants and types for the pan/tilt tracking step.
package ptt_pkg;

    localparam int BYTE_W   = 8;
    localparam int CENTER_W = 15;
    localparam int DBAND_W  = 10;
    localparam int GAIN_W   = 8;
    localparam int ANGLE_W  = 8;
    localparam int COORD_W  = 16;
    localparam int DIFF_W   = COORD_W + 1;          // signed coordinate minus centre
    localparam int MAG_W    = COORD_W;              // |diff| fits unsigned 16 bits
    localparam int PROD_W   = MAG_W + GAIN_W;       // |diff| * gain
    localparam int QUOT_W   = PROD_W;               // quotient of product / centre
    localparam int SUM_W    = QUOT_W + 3;           // signed angle +/- (q + 1)
    localparam int DIV_CNT_W = $clog2(QUOT_W);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = CENTER_W;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

    // packet phase: 0 waits for sync, 1..4 count data bytes
    localparam logic [2:0] PHASE_SYNC = 3'd0;
    localparam logic [2:0] PHASE_LAST = 3'd4;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_CENTER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_CENTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_HIGH  = 3'd5;

    // reset values
    localparam logic [CENTER_W-1:0] PAN_CENTER_RST  = 15'd360;
    localparam logic [CENTER_W-1:0] TILT_CENTER_RST = 15'd340;
    localparam logic [DBAND_W-1:0]  DEAD_BAND_RST   = 10'd35;
    localparam logic [GAIN_W-1:0]   MOVE_GAIN_RST   = 8'd12;
    localparam logic [ANGLE_W-1:0]  ANGLE_LOW_RST   = 8'd0;
    localparam logic [ANGLE_W-1:0]  ANGLE_HIGH_RST  = 8'd180;
    localparam logic [ANGLE_W-1:0]  PAN_POS_RST     = 8'd110;
    localparam logic [ANGLE_W-1:0]  TILT_POS_RST    = 8'd10;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> rtl/pan_tilt_tracking_step.sv
// Top level: packet parser and per-axis proportional update with deadband.
//
// Takes one received serial byte per input transfer. Bytes are dropped until a
// 0xFF sync arrives; the next four bytes are x low, x high, y low, y high, and
// are data even when they equal 0xFF. The last data byte starts the update of
// both axes, which runs through one multiplier stage and one shared 24-step
// restoring divider, pan first, then tilt: for each axis the product, the
// divider start, the divide steps, seeing the divider finish and the angle
// update; then the result is loaded. Input stall is high for that whole
// stretch. An axis whose centre register is zero skips the divider and uses a
// quotient of zero. An axis whose coordinate is more than dead_band from its
// centre moves by trunc((coord - centre) * move_gain / centre) + 1; pan
// subtracts the move, tilt adds it, and the moved angle is clamped to
// [angle_low, angle_high] (above high wins if the limits cross). An axis inside
// the deadband keeps its angle unclamped. One result with both angles leaves
// per packet through an output register, so bytes of the next packet are taken
// while a result still waits. Configuration must be written only while idle;
// the block itself does not enforce it.
module pan_tilt_tracking_step (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [ptt_pkg::BYTE_W-1:0]        i_rx_byte,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [ptt_pkg::ANGLE_W-1:0]       o_pan_angle,
    output logic [ptt_pkg::ANGLE_W-1:0]       o_tilt_angle,
    input  logic                              i_cfg_we,
    input  logic [ptt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ptt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    typedef enum logic [5:0] {
        S_RECV = 6'b000001,   // collecting bytes
        S_MUL  = 6'b000010,   // |d| * gain, deadband test
        S_DIV  = 6'b000100,   // kick the divider
        S_WAIT = 6'b001000,   // divider running
        S_UPD  = 6'b010000,   // apply move and clamp
        S_OUT  = 6'b100000    // load the result register
    } t_state;

    t_state                                 r_state, n_state;

    // configuration
    logic [ptt_pkg::CENTER_W-1:0]           r_pan_center, r_tilt_center;
    logic [ptt_pkg::DBAND_W-1:0]            r_dead_band;
    logic [ptt_pkg::GAIN_W-1:0]             r_move_gain;
    logic [ptt_pkg::ANGLE_W-1:0]            r_angle_low, r_angle_high;

    // packet parsing
    logic [2:0]                             r_phase;
    logic [ptt_pkg::BYTE_W-1:0]             r_coord [3];

    // per-axis working registers
    logic signed [ptt_pkg::DIFF_W-1:0]      r_d_pan, r_d_tilt;
    logic                                   r_axis;      // 0 pan, 1 tilt
    logic                                   r_neg;
    logic                                   r_outside;
    logic [ptt_pkg::PROD_W-1:0]             r_prod;
    logic [ptt_pkg::ANGLE_W-1:0]            r_pan_pos, r_tilt_pos;

    // result register
    logic                                   r_out_valid;
    logic [ptt_pkg::ANGLE_W-1:0]            r_out_pan, r_out_tilt;

    logic                                   w_accept;
    logic                                   w_last;
    logic [ptt_pkg::COORD_W-1:0]            w_x, w_y;
    logic signed [ptt_pkg::DIFF_W-1:0]      w_dx, w_dy, w_d;
    logic [ptt_pkg::DIFF_W-1:0]             w_abs;
    logic [ptt_pkg::MAG_W-1:0]              w_mag;
    logic [ptt_pkg::CENTER_W-1:0]           w_center;
    logic                                   w_czero;
    logic [ptt_pkg::PROD_W-1:0]             w_prod;
    logic                                   w_div_start;
    ptt_pkg::t_div_stat                     w_div_stat;
    logic [ptt_pkg::QUOT_W-1:0]             w_div_quot;
    logic [ptt_pkg::QUOT_W-1:0]             w_q;
    logic signed [ptt_pkg::SUM_W-1:0]       w_qs, w_move, w_pos_s, w_sum;
    logic signed [ptt_pkg::SUM_W-1:0]       w_low_s, w_high_s;
    logic [ptt_pkg::ANGLE_W-1:0]            w_pos, w_clamped;
    logic                                   w_out_free;

    // ---------------- input side ----------------
    assign o_stall  = (r_state != S_RECV);
    assign w_accept = i_valid && !o_stall;
    assign w_last   = w_accept && (r_phase == ptt_pkg::PHASE_LAST);

    // last byte is y high; difference computed as it arrives
    assign w_x  = {r_coord[1], r_coord[0]};
    assign w_y  = {i_rx_byte, r_coord[2]};
    assign w_dx = $signed({1'b0, w_x}) - $signed({2'b00, r_pan_center});
    assign w_dy = $signed({1'b0, w_y}) - $signed({2'b00, r_tilt_center});

    // ---------------- shared axis datapath ----------------
    assign w_d      = r_axis ? r_d_tilt : r_d_pan;
    assign w_abs    = w_d[ptt_pkg::DIFF_W-1] ? (~w_d + 1'b1) : w_d;
    assign w_mag    = w_abs[ptt_pkg::MAG_W-1:0];
    assign w_prod   = ptt_pkg::PROD_W'(w_mag) * ptt_pkg::PROD_W'(r_move_gain);
    assign w_center = r_axis ? r_tilt_center : r_pan_center;
    assign w_czero  = (w_center == '0);

    assign w_div_start = (r_state == S_DIV) && !w_czero;

    ptt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod),
        .i_divisor  (w_center),
        .o_stat     (w_div_stat),
        .o_quotient (w_div_quot)
    );

    // signed move = trunc(d*g/c); quotient sign follows d
    assign w_q      = w_czero ? '0 : w_div_quot;
    assign w_qs     = $signed({3'b000, w_q});
    assign w_move   = r_neg ? -w_qs : w_qs;
    assign w_pos    = r_axis ? r_tilt_pos : r_pan_pos;
    assign w_pos_s  = $signed({{(ptt_pkg::SUM_W-ptt_pkg::ANGLE_W){1'b0}}, w_pos});
    assign w_sum    = r_axis ? (w_pos_s + w_move + ptt_pkg::SUM_W'(1))
                             : (w_pos_s - w_move - ptt_pkg::SUM_W'(1));
    assign w_low_s  = $signed({{(ptt_pkg::SUM_W-ptt_pkg::ANGLE_W){1'b0}}, r_angle_low});
    assign w_high_s = $signed({{(ptt_pkg::SUM_W-ptt_pkg::ANGLE_W){1'b0}}, r_angle_high});

    always_comb begin
        if (w_sum > w_high_s) begin
            w_clamped = r_angle_high;
        end else if (w_sum < w_low_s) begin
            w_clamped = r_angle_low;
        end else begin
            w_clamped = w_sum[ptt_pkg::ANGLE_W-1:0];
        end
    end

    assign w_out_free = !r_out_valid || !i_stall;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RECV: if (w_last) n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV:  n_state = w_czero ? S_UPD : S_WAIT;
            S_WAIT: if (w_div_stat.done) n_state = S_UPD;
            S_UPD:  n_state = r_axis ? S_OUT : S_MUL;
            S_OUT:  if (w_out_free) n_state = S_RECV;
            default: n_state = S_RECV;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_RECV;
            r_phase       <= ptt_pkg::PHASE_SYNC;
            r_axis        <= 1'b0;
            r_pan_pos     <= ptt_pkg::PAN_POS_RST;
            r_tilt_pos    <= ptt_pkg::TILT_POS_RST;
            r_out_valid   <= 1'b0;
            r_pan_center  <= ptt_pkg::PAN_CENTER_RST;
            r_tilt_center <= ptt_pkg::TILT_CENTER_RST;
            r_dead_band   <= ptt_pkg::DEAD_BAND_RST;
            r_move_gain   <= ptt_pkg::MOVE_GAIN_RST;
            r_angle_low   <= ptt_pkg::ANGLE_LOW_RST;
            r_angle_high  <= ptt_pkg::ANGLE_HIGH_RST;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ptt_pkg::CFG_PAN_CENTER:  r_pan_center  <= i_cfg_data;
                    ptt_pkg::CFG_TILT_CENTER: r_tilt_center <= i_cfg_data;
                    ptt_pkg::CFG_DEAD_BAND:
                        r_dead_band  <= i_cfg_data[ptt_pkg::DBAND_W-1:0];
                    ptt_pkg::CFG_MOVE_GAIN:
                        r_move_gain  <= i_cfg_data[ptt_pkg::GAIN_W-1:0];
                    ptt_pkg::CFG_ANGLE_LOW:
                        r_angle_low  <= i_cfg_data[ptt_pkg::ANGLE_W-1:0];
                    ptt_pkg::CFG_ANGLE_HIGH:
                        r_angle_high <= i_cfg_data[ptt_pkg::ANGLE_W-1:0];
                    default: ;
                endcase
            end

            if (w_accept) begin
                if (r_phase == ptt_pkg::PHASE_SYNC) begin
                    if (i_rx_byte == ptt_pkg::SYNC_BYTE) r_phase <= r_phase + 1'b1;
                end else if (w_last) begin
                    r_phase <= ptt_pkg::PHASE_SYNC;
                    r_axis  <= 1'b0;
                end else begin
                    r_phase <= r_phase + 1'b1;
                end
            end

            if (r_state == S_UPD) begin
                if (r_outside) begin
                    if (r_axis) r_tilt_pos <= w_clamped;
                    else        r_pan_pos  <= w_clamped;
                end
                r_axis <= 1'b1;
            end

            // a new result may replace one leaving in the same cycle
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept && (r_phase != ptt_pkg::PHASE_SYNC) && !w_last) begin
            r_coord[2'(r_phase - 1'b1)] <= i_rx_byte;
        end
        if (w_last) begin
            r_d_pan  <= w_dx;
            r_d_tilt <= w_dy;
        end
        if (r_state == S_MUL) begin
            r_prod    <= w_prod;
            r_neg     <= w_d[ptt_pkg::DIFF_W-1];
            r_outside <= (w_mag > ptt_pkg::MAG_W'(r_dead_band));
        end
        if ((r_state == S_OUT) && w_out_free) begin
            r_out_pan  <= r_pan_pos;
            r_out_tilt <= r_tilt_pos;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pan_angle  = r_out_pan;
    assign o_tilt_angle = r_out_tilt;

    // ---------------- assertions ----------------
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_stat.busy)
        else $error("divider started while busy");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_WAIT))
        else $error("divider finished outside the wait state");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && w_out_free) |=> (o_valid && (r_state == S_RECV)))
        else $error("result not presented after load");

endmodule

>>> rtl/ptt_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module ptt_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [ptt_pkg::PROD_W-1:0]        i_dividend,
    input  logic [ptt_pkg::CENTER_W-1:0]      i_divisor,
    output ptt_pkg::t_div_stat                o_stat,
    output logic [ptt_pkg::QUOT_W-1:0]        o_quotient
);

    logic                               r_busy;
    logic                               r_done;
    logic [ptt_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic [ptt_pkg::QUOT_W-1:0]         r_quot;
    logic [ptt_pkg::CENTER_W-1:0]       r_rem;
    logic [ptt_pkg::CENTER_W-1:0]       r_dsor;
    logic [ptt_pkg::CENTER_W:0]         w_trial;
    logic                               w_fits;

    // shift next dividend bit into the partial remainder and try the divisor
    assign w_trial = {r_rem, r_quot[ptt_pkg::QUOT_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_dsor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ptt_pkg::DIV_CNT_W'(ptt_pkg::QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dsor <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[ptt_pkg::QUOT_W-2:0], w_fits};
            if (w_fits) begin
                r_rem <= ptt_pkg::CENTER_W'(w_trial - {1'b0, r_dsor});
            end else begin
                r_rem <= w_trial[ptt_pkg::CENTER_W-1:0];
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quot;

endmodule

>>> tb/pan_tilt_tracking_step_tb.sv
// Self-checking testbench for the pan/tilt tracking step: byte stream in, angle pairs out.
`timescale 1ns / 1ps

module pan_tilt_tracking_step_tb;

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------
    localparam int RESET_CYCLES   = 7;
    localparam int N_SETTINGS     = 8;      // register settings walked by the random part
    localparam int ITEMS_PER_SET  = 135;    // bytes sent per setting, at least
    localparam int PRESSURE_SET   = 2;      // setting during which the output is choked
    localparam int LONG_HOLD      = 500;    // cycles of the long output hold-off
    localparam int TAIL_CYCLES    = 80;     // longer than one full two-axis update
    localparam int RUN_LIMIT_NS   = 5_000_000;
    localparam int DIR_ROWS       = 23;

    // ------------------------------------------------------------------
    // DUT connections; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                           i_clk        = 1'b0;
    logic                           i_rst_n      = 1'b0;
    logic                           i_valid      = 1'b0;
    logic                           o_stall;
    logic [ptt_pkg::BYTE_W-1:0]     i_rx_byte    = '0;
    logic                           o_valid;
    logic                           i_stall      = 1'b0;
    logic [ptt_pkg::ANGLE_W-1:0]    o_pan_angle;
    logic [ptt_pkg::ANGLE_W-1:0]    o_tilt_angle;
    logic                           i_cfg_we     = 1'b0;
    logic [ptt_pkg::CFG_IDX_W-1:0]  i_cfg_idx    = '0;
    logic [ptt_pkg::CFG_DATA_W-1:0] i_cfg_data   = '0;

    pan_tilt_tracking_step dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pan_angle  (o_pan_angle),
        .o_tilt_angle (o_tilt_angle),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Types
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [ptt_pkg::ANGLE_W-1:0] pan;
        logic [ptt_pkg::ANGLE_W-1:0] tilt;
    } t_angle_pair;

    // One directed row: a byte, plus a hand-typed angle pair when the row
    // closes a packet whose outcome is obvious.
    typedef struct packed {
        logic [ptt_pkg::BYTE_W-1:0]  rx;
        logic                        pinned;
        logic [ptt_pkg::ANGLE_W-1:0] pan;
        logic [ptt_pkg::ANGLE_W-1:0] tilt;
    } t_dir_row;

    typedef struct {
        int pan_c;
        int tilt_c;
        int dband;
        int gain;
        int lo;
        int hi;
    } t_reg_set;

    typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_CHOKE} t_rx_mode;

    // ------------------------------------------------------------------
    // Tracking predictor state: mirrors the block's registers and positions
    // ------------------------------------------------------------------
    int          cfg_pan_c  = ptt_pkg::PAN_CENTER_RST;
    int          cfg_tilt_c = ptt_pkg::TILT_CENTER_RST;
    int          cfg_dband  = ptt_pkg::DEAD_BAND_RST;
    int          cfg_gain   = ptt_pkg::MOVE_GAIN_RST;
    int          cfg_lo     = ptt_pkg::ANGLE_LOW_RST;
    int          cfg_hi     = ptt_pkg::ANGLE_HIGH_RST;
    logic [2:0]  pkt_phase  = ptt_pkg::PHASE_SYNC;
    logic [7:0]  coord_b [3];
    int          pan_pos    = ptt_pkg::PAN_POS_RST;
    int          tilt_pos   = ptt_pkg::TILT_POS_RST;

    t_angle_pair pending_angles [$];   // angle pairs owed by the block, oldest first

    // hand-typed expectation for the next packet that completes
    bit          pin_set = 1'b0;
    t_angle_pair pin_pair;

    int          mismatches  = 0;
    bit          hold_off_req = 1'b0;
    int          burst_left  = 0;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // trunc(d * gain / centre) + 1; a zero centre gives a step of 1
    function automatic int axis_step(input int d, input int centre);
        int q;
        q = 0;
        if (centre != 0)
            q = (d * cfg_gain) / centre;   // int division truncates toward zero
        return q + 1;
    endfunction

    // above-high wins when the limits cross
    function automatic int clamp_deg(input int a);
        if (a > cfg_hi)
            return cfg_hi;
        if (a < cfg_lo)
            return cfg_lo;
        return a;
    endfunction

    task automatic track_byte(input logic [7:0] b);
        int          x, y, dx, dy;
        t_angle_pair res;
        if (pkt_phase == ptt_pkg::PHASE_SYNC) begin
            // anything but sync is dropped while hunting
            if (b == ptt_pkg::SYNC_BYTE)
                pkt_phase = ptt_pkg::PHASE_SYNC + 3'd1;
            return;
        end
        if (pkt_phase != ptt_pkg::PHASE_LAST) begin
            // data bytes, 0xFF included
            coord_b[int'(pkt_phase) - 1] = b;
            pkt_phase = pkt_phase + 3'd1;
            return;
        end
        pkt_phase = ptt_pkg::PHASE_SYNC;
        x = {coord_b[1], coord_b[0]};
        y = {b, coord_b[2]};

        // full-width signed difference; inside the band the angle is left untouched
        dx = x - cfg_pan_c;
        if (dx > cfg_dband || dx < -cfg_dband)
            pan_pos = clamp_deg(pan_pos - axis_step(dx, cfg_pan_c));
        dy = y - cfg_tilt_c;
        if (dy > cfg_dband || dy < -cfg_dband)
            tilt_pos = clamp_deg(tilt_pos + axis_step(dy, cfg_tilt_c));

        if (pin_set) begin
            res = pin_pair;
            pin_set = 1'b0;
        end else begin
            res.pan  = pan_pos[ptt_pkg::ANGLE_W-1:0];
            res.tilt = tilt_pos[ptt_pkg::ANGLE_W-1:0];
        end
        pending_angles.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_angles(input logic [7:0] pan, input logic [7:0] tilt);
        t_angle_pair e;
        if (pending_angles.size() == 0) begin
            report_mismatch($sformatf("unexpected result pan=%0d tilt=%0d", pan, tilt));
            return;
        end
        e = pending_angles.pop_front();
        if (pan !== e.pan)
            report_mismatch($sformatf("pan angle %0d, expected %0d", pan, e.pan));
        if (tilt !== e.tilt)
            report_mismatch($sformatf("tilt angle %0d, expected %0d", tilt, e.tilt));
    endtask

    // Both channels are observed at the rising edge, before the block's
    // registers move, so each transfer is seen exactly as the block sees it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                track_byte(i_rx_byte);
            if (o_valid && !i_stall)
                check_angles(o_pan_angle, o_tilt_angle);
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stalls in random modes of random length. On request it
    // keeps i_stall high for the long hold-off, so the output register stays
    // full and the block has to push back on its input.
    // ------------------------------------------------------------------
    initial begin : receiver
        t_rx_mode mode;
        int       span;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(4, 80);
            for (int k = 0; k < span && !hold_off_req; k++) begin
                @(negedge i_clk);
                case (mode)
                    RX_OPEN:    i_stall <= 1'b0;
                    RX_COIN:    i_stall <= 1'($urandom_range(0, 1));
                    RX_PATTERN: i_stall <= (k % 4 != 0);
                    RX_CHOKE:   i_stall <= ($urandom_range(0, 7) != 0);
                    default:    i_stall <= 1'b0;
                endcase
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                repeat (LONG_HOLD) begin
                    @(negedge i_clk);
                    i_stall <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------

    // Offer one byte and hold it until the transfer happens.
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    task automatic idle(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    // Bursts of random length, each opened by a random gap; now and then
    // a long burst gives a stretch with no idling at all.
    task automatic paced_send(input logic [7:0] b);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
            idle(($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(1, 6));
        end
        burst_left--;
        send_byte(b);
    endtask

    // Stop offering and wait until every owed result has come out, then
    // give the block time to finish anything still in flight.
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ptt_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[ptt_pkg::CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        // block is idle, so the predictor can take the new value right away
        case (idx)
            ptt_pkg::CFG_PAN_CENTER:  cfg_pan_c  = value & 32'h7FFF;
            ptt_pkg::CFG_TILT_CENTER: cfg_tilt_c = value & 32'h7FFF;
            ptt_pkg::CFG_DEAD_BAND:   cfg_dband  = value & 32'h3FF;
            ptt_pkg::CFG_MOVE_GAIN:   cfg_gain   = value & 32'hFF;
            ptt_pkg::CFG_ANGLE_LOW:   cfg_lo     = value & 32'hFF;
            ptt_pkg::CFG_ANGLE_HIGH:  cfg_hi     = value & 32'hFF;
            default: ;
        endcase
    endtask

    task automatic load_setting(input t_reg_set s);
        write_reg(ptt_pkg::CFG_PAN_CENTER,  s.pan_c);
        write_reg(ptt_pkg::CFG_TILT_CENTER, s.tilt_c);
        write_reg(ptt_pkg::CFG_DEAD_BAND,   s.dband);
        write_reg(ptt_pkg::CFG_MOVE_GAIN,   s.gain);
        write_reg(ptt_pkg::CFG_ANGLE_LOW,   s.lo);
        write_reg(ptt_pkg::CFG_ANGLE_HIGH,  s.hi);
    endtask

    // Fixed corners first (reset values, extremes, zero gain, zero centres,
    // crossed limits, a pinned angle range), then random settings.
    function automatic t_reg_set pick_setting(input int p);
        t_reg_set s;
        case (p)
            0: s = '{360,   340,   35,   12,  0,   180};
            1: s = '{1,     32767, 0,    255, 0,   180};
            2: s = '{32767, 1,     1023, 0,   90,  90};
            3: s = '{0,     0,     5,    100, 20,  160};
            4: s = '{200,   150,   10,   40,  150, 30};
            5: s = '{640,   480,   1023, 255, 0,   0};
            default: begin
                s.pan_c  = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 1000);
                s.tilt_c = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 1000);
                s.dband  = $urandom_range(0, 1023);
                s.gain   = $urandom_range(0, 255);
                s.lo     = $urandom_range(0, 180);
                s.hi     = $urandom_range(0, 180);
            end
        endcase
        return s;
    endfunction

    // Coordinates cluster around the band edges and the centre, with some
    // full-range values and hard extremes mixed in.
    function automatic logic [15:0] pick_coord(input int centre, input int band);
        int c, span;
        case ($urandom_range(0, 3))
            0: begin
                span = band + 3;
                c = centre + int'($urandom_range(0, 2 * span)) - span;
            end
            1: begin
                span = centre / 2 + 64;
                c = centre + int'($urandom_range(0, 2 * span)) - span;
            end
            2: c = $urandom_range(0, 65535);
            default: begin
                case ($urandom_range(0, 5))
                    0:       c = 0;
                    1:       c = 65535;
                    2:       c = centre + band;
                    3:       c = centre - band;
                    4:       c = centre + band + 1;
                    default: c = centre - band - 1;
                endcase
            end
        endcase
        if (c < 0)
            c = 0;
        if (c > 65535)
            c = 65535;
        return c[15:0];
    endfunction

    // Mostly whole packets; the rest is dropped noise, packets cut short
    // (the next bytes then land as data) and raw random bytes.
    task automatic run_traffic(input int n_items);
        int          sent, kind, cut;
        logic [15:0] x, y;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 99);
            x = pick_coord(cfg_pan_c, cfg_dband);
            y = pick_coord(cfg_tilt_c, cfg_dband);
            if (kind < 75) begin
                paced_send(ptt_pkg::SYNC_BYTE);
                paced_send(x[7:0]);
                paced_send(x[15:8]);
                paced_send(y[7:0]);
                paced_send(y[15:8]);
                sent += 5;
            end else if (kind < 87) begin
                paced_send(8'($urandom_range(0, 8'hFE)));
                sent++;
            end else if (kind < 95) begin
                cut = $urandom_range(1, 3);
                paced_send(ptt_pkg::SYNC_BYTE);
                paced_send(x[7:0]);
                if (cut > 1)
                    paced_send(x[15:8]);
                if (cut > 2)
                    paced_send(y[7:0]);
                sent += cut + 1;
            end else begin
                paced_send(8'($urandom()));
                sent++;
            end
        end
    endtask

    // Directed rows. Only two packets carry typed angles: the centred packet
    // right after reset (nothing moves) and the corner packet that drives
    // both axes past the low limit. The rest go through the predictor.
    function automatic t_dir_row dir_row(input int r);
        t_dir_row d;
        d = '{8'h00, 1'b0, 8'd0, 8'd0};
        case (r)
            0:  d.rx = 8'h00;                       // dropped while hunting
            1:  d.rx = 8'h7F;                       // dropped while hunting
            2:  d.rx = ptt_pkg::SYNC_BYTE;
            3:  d.rx = 8'h68;                       // x = 360, the pan centre
            4:  d.rx = 8'h01;
            5:  d.rx = 8'h54;                       // y = 340, the tilt centre
            6:  d = '{8'h01, 1'b1, 8'd110, 8'd10};  // nothing moves
            7:  d.rx = ptt_pkg::SYNC_BYTE;
            8:  d.rx = 8'hFF;                       // 0xFF inside a packet is data
            9:  d.rx = 8'hFF;                       // x = 65535
            10: d.rx = 8'h00;
            11: d = '{8'h00, 1'b1, 8'd0, 8'd0};     // y = 0: both clamp to low
            12: d.rx = 8'h80;                       // dropped
            13: d.rx = ptt_pkg::SYNC_BYTE;
            14: d.rx = 8'h00;
            15: d.rx = 8'h00;                       // x = 0
            16: d.rx = 8'hFF;
            17: d.rx = 8'hFF;                       // y = 65535: tilt hits high
            18: d.rx = ptt_pkg::SYNC_BYTE;
            19: d.rx = 8'h8C;
            20: d.rx = 8'h01;                       // x = 396, just past the band
            21: d.rx = 8'h31;
            22: d.rx = 8'h01;                       // y = 305, on the band edge
            default: ;
        endcase
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_dir_row row;
        repeat (RESET_CYCLES)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, reset register values
        for (int r = 0; r < DIR_ROWS; r++) begin
            row = dir_row(r);
            if (row.pinned) begin
                pin_pair.pan  = row.pan;
                pin_pair.tilt = row.tilt;
                pin_set       = 1'b1;
            end
            send_byte(row.rx);
        end
        settle();

        // random part, one register setting after another; each ends with
        // the sender paused until every owed result is out
        for (int p = 0; p < N_SETTINGS; p++) begin
            load_setting(pick_setting(p));
            if (p == PRESSURE_SET)
                hold_off_req = 1'b1;
            run_traffic(ITEMS_PER_SET);
            settle();
        end

        if (pending_angles.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_angles.size()));

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
